FILE: rtl/ira_pkg.sv
// ira_pkg: shared constants, types and the digit-to-character function
// for the integer to radix ascii converter; no dependencies
`default_nettype none

package ira_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 8;
  localparam int DIV_BITS        = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A     = 8'h41;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_SEND
  } ira_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ira_qstat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d) - CHAR_W'(DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_to_radix_ascii_core.sv
// integer_to_radix_ascii_core: signed integer to ascii text in base 2..36
// depends on ira_pkg, ira_front, ira_queue and ira_back
//
//   port group  | dir | handshake          | word
//   in_*        | in  | in_valid/in_stall  | in_value, signed VALUE_WIDTH bits
//   out_*       | out | out_valid/out_stall| out_text_char, out_last_char
//   cfg_*       | in  | cfg_wr_en          | cfg_wr_data, radix
//
// per word: pop the job, divide out each digit (8 quotient bits a cycle),
// load a '-' for a negative value, then for each character read the digit
// memory and load the output register
// the two-entry job queue takes new words while the back end is busy
// reset is synchronous, active low; radix resets to 10
`default_nettype none

module integer_to_radix_ascii_core #(
  parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VALUE_WIDTH-1:0]  in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ira_pkg::CHAR_W-1:0]     out_text_char,
  output logic                           out_last_char,
  input  logic                           cfg_wr_en,
  input  logic [ira_pkg::RADIX_W-1:0]    cfg_wr_data
);
  import ira_pkg::*;

  localparam int JOB_W = 1 + RADIX_W + VALUE_WIDTH;

  ira_qstat_t       q_stat;
  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             pop;
  logic [JOB_W-1:0] pop_data;

  ira_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  ira_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ira_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

FILE: rtl/ira_front.sv
// ira_front: radix register, input acceptance, sign split and base clamp
// depends on ira_pkg; pushes one job word per accepted input word
`default_nettype none

module ira_front #(
  parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEF,
  parameter int JOB_W       = 1 + ira_pkg::RADIX_W + VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]   in_value,
  input  logic                            cfg_wr_en,
  input  logic [ira_pkg::RADIX_W-1:0]     cfg_wr_data,
  input  ira_pkg::ira_qstat_t             q_stat,
  output logic                            push,
  output logic [JOB_W-1:0]                push_data
);
  import ira_pkg::*;

  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // most negative value wraps to its unsigned magnitude
  assign raw = in_value;
  assign neg = raw[VALUE_WIDTH-1];
  assign mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

  assign in_stall  = q_stat.full;
  assign push      = in_valid && !q_stat.full;
  assign push_data = {neg, base, mag};

endmodule

`default_nettype wire

FILE: rtl/ira_queue.sv
// ira_queue: two-entry job queue between front and back
// depends on ira_pkg for the status struct
`default_nettype none

module ira_queue #(
  parameter int DATA_W = 1 + ira_pkg::RADIX_W + ira_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  logic                pop,
  output logic [DATA_W-1:0]   pop_data,
  output ira_pkg::ira_qstat_t q_stat
);
  import ira_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

`default_nettype wire

FILE: rtl/ira_back.sv
// ira_back: digit divider, digit memory and character output register
// depends on ira_pkg; pops one job word and emits its characters
`default_nettype none

module ira_back #(
  parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEF,
  parameter int JOB_W       = 1 + ira_pkg::RADIX_W + VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ira_pkg::ira_qstat_t          q_stat,
  input  logic [JOB_W-1:0]             pop_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ira_pkg::CHAR_W-1:0]   out_text_char,
  output logic                         out_last_char
);
  import ira_pkg::*;

  localparam int DIV_CYC = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PW      = DIV_CYC * DIV_BITS;
  localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int AW      = $clog2(VALUE_WIDTH);

  ira_state_t          state_r;
  ira_state_t          state_nxt;
  logic [PW-1:0]       quo_r;
  logic [PW-1:0]       quo_nxt;
  logic [DIGIT_W-1:0]  rem_r;
  logic [DIGIT_W-1:0]  rem_nxt;
  logic [RADIX_W-1:0]  base_r;
  logic                neg_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_dec;
  logic [DIGIT_W-1:0]  digit_mem [VALUE_WIDTH];
  logic [DIGIT_W-1:0]  rd_data_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic out_free;
  logic div_last;
  logic quo_zero;
  logic div_en;
  logic digit_wr;
  logic rd_en;
  logic load_sign;
  logic load_digit;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0]   t;
    logic               ge;
    logic [DIGIT_W-1:0] r;
    logic [PW-1:0]      q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {r, q[PW-1]};
      ge = (t >= {1'b0, base_r});
      r  = ge ? DIGIT_W'(t - {1'b0, base_r}) : t[DIGIT_W-1:0];
      q  = {q[PW-2:0], ge};
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign div_last = (step_r == STEP_W'(DIV_CYC - 1));
  assign quo_zero = (quo_nxt == '0);
  assign cnt_dec  = cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last && quo_zero) begin
          state_nxt = neg_r ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          state_nxt = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    div_en     = 1'b0;
    digit_wr   = 1'b0;
    rd_en      = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        pop = !q_stat.empty;
      end
      ST_DIV: begin
        div_en   = 1'b1;
        digit_wr = div_last;
      end
      ST_SIGN: begin
        load_sign = out_free;
      end
      ST_FETCH: begin
        rd_en = 1'b1;
      end
      ST_SEND: begin
        load_digit = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        step_r <= '0;
        cnt_r  <= '0;
      end else if (div_en) begin
        step_r <= div_last ? '0 : step_r + STEP_W'(1);
        if (div_last) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (load_digit) begin
        cnt_r <= cnt_dec;
      end
      if (load_sign || load_digit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg_r  <= pop_data[JOB_W-1];
      base_r <= pop_data[VALUE_WIDTH +: RADIX_W];
      quo_r  <= PW'(pop_data[VALUE_WIDTH-1:0]);
      rem_r  <= '0;
    end else if (div_en) begin
      quo_r <= quo_nxt;
      rem_r <= div_last ? '0 : rem_nxt;
    end
    if (digit_wr) begin
      digit_mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[cnt_dec[AW-1:0]];
    end
    if (load_sign) begin
      out_char_r <= ASCII_MINUS;
      out_last_r <= 1'b0;
    end else if (load_digit) begin
      out_char_r <= digit_to_ascii(rd_data_r);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/ira_checker.sv
// ira_checker: port-level assertions on the character output channel
// depends on ira_pkg; bound to integer_to_radix_ascii_core
`default_nettype none

module ira_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ira_pkg::CHAR_W-1:0] out_text_char,
  input logic                       out_last_char
);
  import ira_pkg::*;

  logic is_minus;
  logic is_digit;
  logic is_letter;

  assign is_minus  = (out_text_char == ASCII_MINUS);
  assign is_digit  = (out_text_char >= ASCII_ZERO) && (out_text_char <= 8'h39);
  assign is_letter = (out_text_char >= ASCII_A) && (out_text_char <= 8'h5A);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_text_char)
      && $stable(out_last_char))
    else $error("stalled output word changed");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_minus || is_digit || is_letter)
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_minus |-> !out_last_char)
    else $error("sign flagged as last character");

  a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && is_minus |=> !(out_valid && is_minus))
    else $error("two sign characters in a row");

endmodule

bind integer_to_radix_ascii_core ira_checker u_ira_checker (.*);

`default_nettype wire
